// ===== rtl/rdiv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdiv_pkg
// Shared types and constants for the pipelined restoring divider.
// ----------------------------------------------------------------------------
package rdiv_pkg;

  localparam int FIELD_W   = 64;
  localparam int DATA_W_DF = 64;

  typedef enum logic {
    MODE_UNSIGNED = 1'b0,
    MODE_SIGNED   = 1'b1
  } mode_t;

  typedef struct packed {
    logic               cmd;
    logic [FIELD_W-1:0] dividend;
    logic [FIELD_W-1:0] divisor;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] quotient;
    logic [FIELD_W-1:0] remainder;
    logic               div_by_zero;
  } out_item_t;

  typedef struct packed {
    logic valid;
    logic flip;
    logic dz;
  } stage_ctl_t;

endpackage

// ===== rtl/rdiv_prep.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdiv_prep
// Input stage: takes operand magnitudes in signed mode and records the
// quotient sign and the zero divisor case.
// ----------------------------------------------------------------------------
module rdiv_prep
  import rdiv_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_W_DF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  in_item_t              in_item,
  output stage_ctl_t            ctl_r,
  output logic [DATA_WIDTH-1:0] num_r,
  output logic [DATA_WIDTH-1:0] den_r
);

  logic [DATA_WIDTH-1:0] a;
  logic [DATA_WIDTH-1:0] b;
  logic                  a_neg;
  logic                  b_neg;
  logic [DATA_WIDTH-1:0] num_nxt;
  logic [DATA_WIDTH-1:0] den_nxt;
  stage_ctl_t            ctl_nxt;

  always_comb begin
    a       = in_item.dividend[DATA_WIDTH-1:0];
    b       = in_item.divisor[DATA_WIDTH-1:0];
    a_neg   = (in_item.cmd == MODE_SIGNED) && a[DATA_WIDTH-1];
    b_neg   = (in_item.cmd == MODE_SIGNED) && b[DATA_WIDTH-1];
    num_nxt = a_neg ? (~a + 1'b1) : a;
    den_nxt = b_neg ? (~b + 1'b1) : b;
    ctl_nxt.valid = in_valid;
    ctl_nxt.flip  = a_neg ^ b_neg;
    ctl_nxt.dz    = (b == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (en) begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= num_nxt;
      den_r <= den_nxt;
    end
  end

endmodule

// ===== rtl/rdiv_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdiv_step
// One restoring division step: shifts the next dividend bit into the
// partial remainder, subtracts the divisor when it fits and shifts the
// quotient bit into the freed low end of the dividend register.
// ----------------------------------------------------------------------------
module rdiv_step
  import rdiv_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_W_DF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  stage_ctl_t            ctl_i,
  input  logic [DATA_WIDTH-1:0] rem_i,
  input  logic [DATA_WIDTH-1:0] nq_i,
  input  logic [DATA_WIDTH-1:0] den_i,
  output stage_ctl_t            ctl_r,
  output logic [DATA_WIDTH-1:0] rem_r,
  output logic [DATA_WIDTH-1:0] nq_r,
  output logic [DATA_WIDTH-1:0] den_r
);

  logic                  carry;
  logic [DATA_WIDTH-1:0] shifted;
  logic [DATA_WIDTH-1:0] diff;
  logic                  take;
  logic [DATA_WIDTH-1:0] rem_nxt;
  logic [DATA_WIDTH-1:0] nq_nxt;

  always_comb begin
    carry   = rem_i[DATA_WIDTH-1];
    shifted = {rem_i[DATA_WIDTH-2:0], nq_i[DATA_WIDTH-1]};
    diff    = shifted - den_i;
    take    = carry || (shifted >= den_i);
    rem_nxt = take ? diff : shifted;
    nq_nxt  = {nq_i[DATA_WIDTH-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      nq_r  <= nq_nxt;
      den_r <= den_i;
    end
  end

endmodule

// ===== rtl/rdiv_fix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdiv_fix
// Output stage: applies the quotient sign, forces zero results for a zero
// divisor and holds the finished item for the result channel.
// ----------------------------------------------------------------------------
module rdiv_fix
  import rdiv_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_W_DF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  stage_ctl_t            ctl_i,
  input  logic [DATA_WIDTH-1:0] quo_i,
  input  logic [DATA_WIDTH-1:0] rem_i,
  output logic                  out_valid_r,
  output out_item_t             out_item_r
);

  logic [DATA_WIDTH-1:0] quo_s;
  out_item_t             item_nxt;

  always_comb begin
    quo_s = ctl_i.flip ? (~quo_i + 1'b1) : quo_i;
    item_nxt.div_by_zero = ctl_i.dz;
    item_nxt.quotient    = ctl_i.dz ? '0 : FIELD_W'(quo_s);
    item_nxt.remainder   = ctl_i.dz ? '0 : FIELD_W'(rem_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item_r <= item_nxt;
    end
  end

endmodule

// ===== rtl/restoring_divider_64.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// restoring_divider_64
// Pipelined restoring divider, signed or unsigned, one quotient bit per stage.
//
//   Channel  Ports                      Payload      Direction
//   input    in_valid, in_stall         in_item_t    into the block
//   result   out_valid, out_stall       out_item_t   out of the block
//
// An item is accepted in every cycle in which the result register is free
// or is being taken. An item passes through one operand stage, one stage
// per quotient bit and one sign and output stage.
// A stalled result freezes the whole pipeline; in_stall follows it.
// Reset clears only the valid bits of the stages.
// ----------------------------------------------------------------------------
module restoring_divider_64
  import rdiv_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_W_DF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic                  en;
  stage_ctl_t            ctl_s [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] rem_s [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] nq_s  [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] den_s [DATA_WIDTH+1];

  assign in_stall = out_valid && out_stall;
  assign en       = !in_stall;
  assign rem_s[0] = '0;

  rdiv_prep #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_valid(in_valid),
    .in_item (in_item),
    .ctl_r   (ctl_s[0]),
    .num_r   (nq_s[0]),
    .den_r   (den_s[0])
  );

  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_step
    rdiv_step #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_step (
      .clk  (clk),
      .rst_n(rst_n),
      .en   (en),
      .ctl_i(ctl_s[i]),
      .rem_i(rem_s[i]),
      .nq_i (nq_s[i]),
      .den_i(den_s[i]),
      .ctl_r(ctl_s[i+1]),
      .rem_r(rem_s[i+1]),
      .nq_r (nq_s[i+1]),
      .den_r(den_s[i+1])
    );
  end

  rdiv_fix #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_fix (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .ctl_i      (ctl_s[DATA_WIDTH]),
    .quo_i      (nq_s[DATA_WIDTH]),
    .rem_i      (rem_s[DATA_WIDTH]),
    .out_valid_r(out_valid),
    .out_item_r (out_item)
  );

  // For a valid item with a nonzero divisor, the final partial remainder is below the divisor magnitude.
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_s[DATA_WIDTH].valid && !ctl_s[DATA_WIDTH].dz)
      |-> (rem_s[DATA_WIDTH] < den_s[DATA_WIDTH]))
    else $error("final remainder not below divisor");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.div_by_zero)
      |-> (out_item.quotient == '0 && out_item.remainder == '0))
    else $error("zero divisor result not cleared");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(ctl_s[DATA_WIDTH].valid) && $stable(nq_s[DATA_WIDTH])))
    else $error("pipeline moved while stalled");

  a_dz_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_s[0].valid && en) |=> (ctl_s[1].dz == (den_s[1] == '0)))
    else $error("zero divisor flag lost its operand");

endmodule

// ===== dv/tb_restoring_divider_64.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_restoring_divider_64
// Self-checking testbench for the pipelined restoring divider.
//
// Directed items cover the operand extremes, division by zero, the most
// negative value divided by -1 and each signed mix that has a negative operand.
// Random items in both modes follow. Some run with random sender gaps and
// result stalls, one runs with no idling at all, and some run in groups where
// the sender waits for the pipeline to drain. Each accepted item is predicted
// on the spot. Each result is compared field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb_restoring_divider_64;
  import rdiv_pkg::*;

  localparam int LATENCY      = FIELD_W + 2;
  localparam int LIMIT_CYCLES = 400000;

  localparam logic [FIELD_W-1:0] ALL_ONES = {FIELD_W{1'b1}};
  localparam logic [FIELD_W-1:0] MOST_NEG = {1'b1, {(FIELD_W-1){1'b0}}};
  localparam logic [FIELD_W-1:0] MOST_POS = {1'b0, {(FIELD_W-1){1'b1}}};

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  out_item_t expected_divisions[$];
  int        mismatch_count = 0;
  int        cycle_count    = 0;
  bit        idle_on        = 1'b1;

  restoring_divider_64 dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= idle_on && ($urandom_range(99) < 10);
  end

  function automatic out_item_t predict_division(input in_item_t item);
    out_item_t res;
    logic [FIELD_W-1:0] num;
    logic [FIELD_W-1:0] den;
    logic [FIELD_W-1:0] quo;
    logic negate;
    res    = '0;
    num    = item.dividend;
    den    = item.divisor;
    negate = 1'b0;
    if (den == '0) begin
      res.div_by_zero = 1'b1;
      return res;
    end
    // Signed mode divides the magnitudes; the most negative value stays
    // 2^(W-1) as an unsigned magnitude.
    if (mode_t'(item.cmd) == MODE_SIGNED) begin
      if (num[FIELD_W-1]) begin
        num    = -num;
        negate = ~negate;
      end
      if (den[FIELD_W-1]) begin
        den    = -den;
        negate = ~negate;
      end
    end
    quo           = num / den;
    res.quotient  = negate ? -quo : quo;
    res.remainder = num % den;
    return res;
  endfunction

  function automatic in_item_t make_item(input mode_t mode, input logic [FIELD_W-1:0] a,
                                         input logic [FIELD_W-1:0] b);
    in_item_t item;
    item.cmd      = mode;
    item.dividend = a;
    item.divisor  = b;
    return item;
  endfunction

  function automatic logic [FIELD_W-1:0] random_operand();
    logic [FIELD_W-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(7))
      0, 1, 2: begin
      end
      3, 4: begin
        v = v >> $urandom_range(FIELD_W - 1);
      end
      5: begin
        v = -(v >> $urandom_range(FIELD_W - 1));
      end
      6: begin
        v = v >> (FIELD_W - 8);
      end
      default: begin
        case ($urandom_range(3))
          0: v = ALL_ONES;
          1: v = MOST_NEG;
          2: v = MOST_POS;
          default: v = '0;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic in_item_t random_item(input mode_t mode);
    logic [FIELD_W-1:0] den;
    den = ($urandom_range(99) < 3) ? '0 : random_operand();
    return make_item(mode, random_operand(), den);
  endfunction

  task automatic report_mismatch(input string field, input logic [FIELD_W-1:0] want,
                                 input logic [FIELD_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("Mismatch in %s: expected %h, got %h", field, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_divisions.size() == 0) begin
        report_mismatch("unexpected result quotient", '0, out_item.quotient);
      end else begin
        want = expected_divisions.pop_front();
        if (out_item.quotient !== want.quotient) begin
          report_mismatch("quotient", want.quotient, out_item.quotient);
        end
        if (out_item.remainder !== want.remainder) begin
          report_mismatch("remainder", want.remainder, out_item.remainder);
        end
        if (out_item.div_by_zero !== want.div_by_zero) begin
          report_mismatch("div_by_zero", FIELD_W'(want.div_by_zero),
                          FIELD_W'(out_item.div_by_zero));
        end
      end
    end
  end

  // Leaves in_valid high so that a following item goes out back to back.
  task automatic send_item(input in_item_t item);
    while (idle_on && ($urandom_range(99) < 10)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    do begin
      @(posedge clk);
    end while (in_stall);
    expected_divisions.push_back(predict_division(item));
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (expected_divisions.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic test_directed();
    send_item(make_item(MODE_UNSIGNED, '0, '0));
    send_item(make_item(MODE_UNSIGNED, ALL_ONES, '0));
    send_item(make_item(MODE_UNSIGNED, ALL_ONES, 64'd1));
    send_item(make_item(MODE_UNSIGNED, ALL_ONES, ALL_ONES));
    send_item(make_item(MODE_UNSIGNED, '0, ALL_ONES));
    send_item(make_item(MODE_UNSIGNED, 64'd1, ALL_ONES));
    send_item(make_item(MODE_UNSIGNED, ALL_ONES, MOST_NEG));
    send_item(make_item(MODE_UNSIGNED, 64'd100, 64'd7));
    send_item(make_item(MODE_UNSIGNED, 64'd7, 64'd100));
    send_item(make_item(MODE_UNSIGNED, MOST_NEG, 64'd3));
    send_item(make_item(MODE_SIGNED, MOST_NEG, '0));
    send_item(make_item(MODE_SIGNED, MOST_NEG, ALL_ONES));
    send_item(make_item(MODE_SIGNED, MOST_NEG, 64'd1));
    send_item(make_item(MODE_SIGNED, MOST_NEG, MOST_NEG));
    send_item(make_item(MODE_SIGNED, MOST_NEG, 64'd2));
    send_item(make_item(MODE_SIGNED, ALL_ONES, ALL_ONES));
    send_item(make_item(MODE_SIGNED, -64'd7, 64'd2));
    send_item(make_item(MODE_SIGNED, 64'd7, -64'd2));
    send_item(make_item(MODE_SIGNED, -64'd7, -64'd2));
    send_item(make_item(MODE_SIGNED, MOST_POS, ALL_ONES));
    send_item(make_item(MODE_SIGNED, ALL_ONES, MOST_NEG));
    send_item(make_item(MODE_SIGNED, MOST_POS, MOST_NEG));
    send_item(make_item(MODE_SIGNED, '0, -64'd5));
    stop_sending();
  endtask

  task automatic test_unsigned_random(input int count);
    repeat (count) send_item(random_item(MODE_UNSIGNED));
    stop_sending();
  endtask

  task automatic test_signed_random(input int count);
    repeat (count) send_item(random_item(MODE_SIGNED));
    stop_sending();
  endtask

  task automatic test_full_rate(input int count);
    idle_on = 1'b0;
    repeat (count) send_item(random_item(mode_t'($urandom_range(1))));
    stop_sending();
    idle_on = 1'b1;
  endtask

  task automatic test_drain_between_groups(input int groups, input int group_size);
    repeat (groups) begin
      repeat (group_size) send_item(random_item(mode_t'($urandom_range(1))));
      stop_sending();
      wait_drained();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_unsigned_random(140);
    test_signed_random(140);
    test_full_rate(120);
    test_drain_between_groups(5, 25);
    wait_drained();
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
